// ----- hdl/bsp_pkg.sv -----
// Shared types, constants and helper functions for the Bezier surface patch engine.
// No dependencies; every other file of the block uses this package.
package bsp_pkg;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } fin_t;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Binomial coefficients C(n,k) for n up to seven.
  localparam logic [5:0] BINOM [8][8] = '{
    '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
    '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
    '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
  };

  // Rounds a Q18.46 accumulator to Q16.16 (halves toward plus infinity) and saturates.
  function automatic fin_t finish_f(input logic [63:0] acc);
    logic [63:0] x;
    logic [33:0] r;
    fin_t        f;
    x      = acc + 64'h0000_0000_2000_0000;
    r      = x[63:30];
    f.clip = !((r[33] == r[32]) && (r[32] == r[31]));
    if (!f.clip) begin
      f.val = r[31:0];
    end else if (r[33]) begin
      f.val = 32'h8000_0000;
    end else begin
      f.val = 32'h7FFF_FFFF;
    end
    return f;
  endfunction

endpackage

// ----- hdl/bsp_basis.sv -----
// Bernstein basis unit: powers of p and 1-p, then binomial-weighted products, in Q30.
// Depends on bsp_pkg for the binomial table and fixed-point constants.
module bsp_basis #(
  parameter int unsigned DEGREE = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] param_i,
  output logic        done_o,
  output logic [30:0] basis_o [DEGREE+1]
);

  localparam int unsigned KW = $clog2(DEGREE + 1);
  localparam logic [KW-1:0] KLAST = KW'(DEGREE);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_POW   = 2'd1;
  localparam logic [1:0] B_MUL   = 2'd2;
  localparam logic [1:0] B_DRAIN = 2'd3;

  logic [1:0]    state_q;
  logic [KW-1:0] k_q;
  logic [KW-1:0] pk_q;
  logic          pv_q;
  logic          done_q;
  logic [15:0]   p_q;
  logic [15:0]   q_q;
  logic [30:0]   pu_q [DEGREE+1];
  logic [30:0]   pw_q [DEGREE+1];
  logic [30:0]   b_q  [DEGREE+1];
  logic [61:0]   prod_q;

  logic [46:0] pu_m;
  logic [46:0] pw_m;
  logic [30:0] pu_nx;
  logic [30:0] pw_nx;
  logic [30:0] r_c;
  logic [36:0] bv_c;
  logic [30:0] bsat_c;

  always_comb begin
    pu_m   = 47'(pu_q[k_q - KW'(1)]) * 47'(p_q);
    pw_m   = 47'(pw_q[k_q - KW'(1)]) * 47'(q_q);
    pu_nx  = 31'((pu_m + 47'(16384)) >> 15);
    pw_nx  = 31'((pw_m + 47'(16384)) >> 15);
    r_c    = 31'((prod_q + 62'(1 << 29)) >> 30);
    bv_c   = 37'(bsp_pkg::BINOM[3'(DEGREE)][3'(pk_q)]) * 37'(r_c);
    bsat_c = (bv_c > 37'(bsp_pkg::ONE_Q30)) ? bsp_pkg::ONE_Q30 : 31'(bv_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pv_q   <= (state_q == B_MUL);
      done_q <= pv_q && (pk_q == KLAST);
      unique case (state_q)
        B_IDLE: begin
          if (start_i) begin
            state_q <= B_POW;
            k_q     <= KW'(1);
          end
        end
        B_POW: begin
          if (k_q == KLAST) begin
            k_q     <= '0;
            state_q <= B_MUL;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        B_MUL: begin
          if (k_q == KLAST) begin
            state_q <= B_DRAIN;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        B_DRAIN: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && start_i) begin
      p_q     <= param_i;
      q_q     <= bsp_pkg::ONE_Q15 - param_i;
      pu_q[0] <= bsp_pkg::ONE_Q30;
      pw_q[0] <= bsp_pkg::ONE_Q30;
    end
    if (state_q == B_POW) begin
      pu_q[k_q] <= pu_nx;
      pw_q[k_q] <= pw_nx;
    end
    if (state_q == B_MUL) begin
      prod_q <= 62'(pu_q[k_q]) * 62'(pw_q[KLAST - k_q]);
      pk_q   <= k_q;
    end
    if (pv_q) begin
      b_q[pk_q] <= bsat_c;
    end
  end

  assign done_o  = done_q;
  assign basis_o = b_q;

endmodule

// ----- hdl/bsp_point_mem.sv -----
// Control point store: one write port, one registered read port, valid bit per entry.
// Depends on bsp_pkg for the point type; an entry never written reads as zero.
module bsp_point_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  bsp_pkg::point_t  wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output bsp_pkg::point_t  rdata_o
);

  bsp_pkg::point_t mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  bsp_pkg::point_t rd_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- hdl/bezier_surface_patch_engine.sv -----
// Top level of the Bezier surface patch engine: item sequencer, sweep pipeline, output register.
// Depends on bsp_pkg, bsp_basis and bsp_point_mem.
//
//   channel  | handshake                 | payload
//   input    | in_valid_i / in_stall_o   | command_i, point_x/y/z_i, param_u/v_i
//   output   | out_valid_o / out_stall_i | surf_x/y/z_o, grid_complete_o, touched_row/col_o,
//            |                           | clipped_o
//
// A place item while the grid still fills writes its point at the next fill position. A place
// item on a full grid sweeps the point memory once, one entry per cycle. An evaluate item
// first runs the basis units, then the same sweep.
// The single read port of the point memory sets the sweep length. Reset clears all points.
// One item is in work at a time; the next is taken once the result sits in the output register.
module bezier_surface_patch_engine #(
  parameter int unsigned ROW_DEGREE = 3,
  parameter int unsigned COL_DEGREE = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  input  logic [15:0] param_u_i,
  input  logic [15:0] param_v_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] surf_x_o,
  output logic [31:0] surf_y_o,
  output logic [31:0] surf_z_o,
  output logic        grid_complete_o,
  output logic [2:0]  touched_row_o,
  output logic [2:0]  touched_col_o,
  output logic        clipped_o
);

  localparam int unsigned NROWS = ROW_DEGREE + 1;
  localparam int unsigned NCOLS = COL_DEGREE + 1;
  localparam int unsigned NPTS  = NROWS * NCOLS;
  localparam int unsigned AW    = $clog2(NPTS);
  localparam int unsigned RW    = $clog2(NROWS);
  localparam int unsigned CW    = $clog2(NCOLS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BASIS = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q;
  logic       accept;
  logic       place_load;
  logic       pipe_empty;
  logic       near_wr;
  logic       out_free;

  // Grid fill position.
  logic [AW-1:0] load_addr_q;
  logic [RW-1:0] load_row_q;
  logic [CW-1:0] load_col_q;
  logic          grid_done_q;

  bsp_pkg::point_t pt_q;
  logic            mode_eval_q;

  // Basis units.
  logic [15:0] u_sat;
  logic [15:0] v_sat;
  logic        bu_done;
  logic        bv_done;
  logic        bu_ok_q;
  logic        bv_ok_q;
  logic [30:0] bu [NROWS];
  logic [30:0] bv [NCOLS];

  // Sweep issue counters.
  logic [AW-1:0] addr_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;

  // Point memory.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  bsp_pkg::point_t mem_wdata;
  bsp_pkg::point_t mem_rdata;

  // Pipeline stages.
  logic          v1_q, v2_q, v3_q;
  logic [AW-1:0] a1_q, a2_q, a3_q;
  logic [RW-1:0] r1_q, r2_q, r3_q;
  logic [CW-1:0] c1_q, c2_q, c3_q;
  logic [61:0]   wprod_q;
  logic signed [33:0] opa2_q [3];
  logic signed [33:0] opb2_q [3];
  logic [65:0]   p3_q [3];

  logic [31:0]        rd_c   [3];
  logic [31:0]        pt_c   [3];
  logic signed [32:0] diff_c [3];
  logic [32:0]        mag_c  [3];
  logic [30:0]        w1_c;
  logic signed [33:0] opa_c  [3];
  logic signed [33:0] opb_c  [3];
  logic signed [67:0] prod_c [3];
  logic [65:0]        sum_c;

  // Reduction state.
  logic [63:0]   acc_q [3];
  logic [65:0]   best_q;
  logic [AW-1:0] best_addr_q;
  logic [RW-1:0] best_row_q;
  logic [CW-1:0] best_col_q;
  logic          first_q;

  bsp_pkg::fin_t fin_c [3];

  // Result and output registers.
  bsp_pkg::point_t res_pt_q;
  logic [2:0]      res_row_q;
  logic [2:0]      res_col_q;
  logic            res_clip_q;
  logic            out_valid_q;
  bsp_pkg::point_t out_pt_q;
  logic            out_grid_q;
  logic [2:0]      out_row_q;
  logic [2:0]      out_col_q;
  logic            out_clip_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign place_load = accept && !command_i && !grid_done_q;
  assign pipe_empty = !v1_q && !v2_q && !v3_q;
  assign near_wr    = (state_q == S_DRAIN) && pipe_empty && !mode_eval_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign u_sat = (param_u_i > bsp_pkg::ONE_Q15) ? bsp_pkg::ONE_Q15 : param_u_i;
  assign v_sat = (param_v_i > bsp_pkg::ONE_Q15) ? bsp_pkg::ONE_Q15 : param_v_i;

  bsp_basis #(.DEGREE(ROW_DEGREE)) u_basis_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && command_i),
    .param_i (u_sat),
    .done_o  (bu_done),
    .basis_o (bu)
  );

  bsp_basis #(.DEGREE(COL_DEGREE)) u_basis_col (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && command_i),
    .param_i (v_sat),
    .done_o  (bv_done),
    .basis_o (bv)
  );

  assign mem_we    = place_load || near_wr;
  assign mem_waddr = place_load ? load_addr_q : best_addr_q;
  assign mem_wdata = place_load ? {point_x_i, point_y_i, point_z_i} : pt_q;

  bsp_point_mem #(.DEPTH(NPTS), .AW(AW)) u_point_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  // Stage one forms either the weight and signed coordinate or the distance magnitudes;
  // stage two shares one multiplier per axis between both item kinds.
  always_comb begin
    rd_c[0] = mem_rdata.x;
    rd_c[1] = mem_rdata.y;
    rd_c[2] = mem_rdata.z;
    pt_c[0] = pt_q.x;
    pt_c[1] = pt_q.y;
    pt_c[2] = pt_q.z;
    w1_c    = 31'((wprod_q + 62'(1 << 29)) >> 30);
    for (int l = 0; l < 3; l++) begin
      diff_c[l] = 33'($signed(pt_c[l])) - 33'($signed(rd_c[l]));
      mag_c[l]  = diff_c[l][32] ? 33'(-diff_c[l]) : 33'(diff_c[l]);
      opa_c[l]  = mode_eval_q ? 34'($signed(rd_c[l])) : $signed({1'b0, mag_c[l]});
      opb_c[l]  = mode_eval_q ? $signed({3'b000, w1_c}) : $signed({1'b0, mag_c[l]});
      prod_c[l] = opa2_q[l] * opb2_q[l];
      fin_c[l]  = bsp_pkg::finish_f(acc_q[l]);
    end
    sum_c = p3_q[0] + p3_q[1] + p3_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_addr_q <= '0;
      load_row_q  <= '0;
      load_col_q  <= '0;
      grid_done_q <= 1'b0;
      bu_ok_q     <= 1'b0;
      bv_ok_q     <= 1'b0;
      addr_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= (state_q == S_SWEEP);
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        first_q <= 1'b0;
      end
      if (place_load) begin
        if (load_addr_q == AW'(NPTS - 1)) begin
          load_addr_q <= '0;
        end else begin
          load_addr_q <= load_addr_q + AW'(1);
        end
        if (load_col_q == CW'(NCOLS - 1)) begin
          load_col_q <= '0;
          if (load_row_q == RW'(NROWS - 1)) begin
            load_row_q  <= '0;
            grid_done_q <= 1'b1;
          end else begin
            load_row_q <= load_row_q + RW'(1);
          end
        end else begin
          load_col_q <= load_col_q + CW'(1);
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          addr_q  <= '0;
          row_q   <= '0;
          col_q   <= '0;
          first_q <= 1'b1;
          bu_ok_q <= 1'b0;
          bv_ok_q <= 1'b0;
          if (accept) begin
            if (command_i) begin
              state_q <= S_BASIS;
            end else if (!grid_done_q) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SWEEP;
            end
          end
        end
        S_BASIS: begin
          bu_ok_q <= bu_ok_q || bu_done;
          bv_ok_q <= bv_ok_q || bv_done;
          if ((bu_ok_q || bu_done) && (bv_ok_q || bv_done)) begin
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          addr_q <= addr_q + AW'(1);
          if (col_q == CW'(NCOLS - 1)) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
          if (addr_q == AW'(NPTS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pipe_empty) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q        <= {point_x_i, point_y_i, point_z_i};
      mode_eval_q <= command_i;
    end
    if (place_load) begin
      res_pt_q   <= '0;
      res_row_q  <= 3'(load_row_q);
      res_col_q  <= 3'(load_col_q);
      res_clip_q <= 1'b0;
    end

    // Sweep pipeline payload.
    wprod_q <= 62'(bu[row_q]) * 62'(bv[col_q]);
    a1_q    <= addr_q;
    r1_q    <= row_q;
    c1_q    <= col_q;
    a2_q    <= a1_q;
    r2_q    <= r1_q;
    c2_q    <= c1_q;
    a3_q    <= a2_q;
    r3_q    <= r2_q;
    c3_q    <= c2_q;
    for (int l = 0; l < 3; l++) begin
      opa2_q[l] <= opa_c[l];
      opb2_q[l] <= opb_c[l];
      p3_q[l]   <= prod_c[l][65:0];
    end

    if (state_q == S_IDLE) begin
      for (int l = 0; l < 3; l++) begin
        acc_q[l] <= '0;
      end
    end else if (v3_q) begin
      for (int l = 0; l < 3; l++) begin
        acc_q[l] <= acc_q[l] + p3_q[l][63:0];
      end
    end

    // Strict less-than keeps the earliest point in row-major order on a tie.
    if (v3_q && (first_q || sum_c < best_q)) begin
      best_q      <= sum_c;
      best_addr_q <= a3_q;
      best_row_q  <= r3_q;
      best_col_q  <= c3_q;
    end

    if (state_q == S_DRAIN && pipe_empty) begin
      if (mode_eval_q) begin
        res_pt_q   <= {fin_c[0].val, fin_c[1].val, fin_c[2].val};
        res_clip_q <= fin_c[0].clip || fin_c[1].clip || fin_c[2].clip;
        res_row_q  <= '0;
        res_col_q  <= '0;
      end else begin
        res_pt_q   <= '0;
        res_clip_q <= 1'b0;
        res_row_q  <= 3'(best_row_q);
        res_col_q  <= 3'(best_col_q);
      end
    end

    if (state_q == S_DONE && out_free) begin
      out_pt_q   <= res_pt_q;
      out_grid_q <= grid_done_q;
      out_row_q  <= res_row_q;
      out_col_q  <= res_col_q;
      out_clip_q <= res_clip_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign surf_x_o        = out_pt_q.x;
  assign surf_y_o        = out_pt_q.y;
  assign surf_z_o        = out_pt_q.z;
  assign grid_complete_o = out_grid_q;
  assign touched_row_o   = out_row_q;
  assign touched_col_o   = out_col_q;
  assign clipped_o       = out_clip_q;

`ifndef SYNTH
  a_touch_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(touched_row_o) < NROWS) && (int'(touched_col_o) < NCOLS))
    else $error("touched position outside the grid");

  a_grid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_done_q |=> grid_done_q)
    else $error("grid completion flag dropped");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE || state_q == S_DRAIN))
    else $error("point memory written during a sweep");

  a_pipe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (state_q == S_SWEEP || state_q == S_DRAIN))
    else $error("sweep pipeline active outside a sweep");
`endif

endmodule
